[rtl/core/ffba_pkg.sv]
// ffba_pkg: field widths, status and command codes for the first-fit block allocator
// no dependencies; imported by ffba_marker_mem and first_fit_block_allocator
package ffba_pkg;

    localparam int ADDR_W     = 16;
    localparam int REQ_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int FREED_W    = 7;
    localparam int FBYTES_W   = 11;
    localparam int MARK_W     = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - ADDR_W - FREED_W - FBYTES_W;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [MARK_W-1:0]   mark_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_ZERO_SIZE = 2'd1;
    localparam status_t ST_NO_MEM    = 2'd2;
    localparam status_t ST_BAD_ADDR  = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

endpackage

[rtl/core/ffba_marker_mem.sv]
// ffba_marker_mem: owner marker memory, one write and one registered read per cycle
// entries never written read as zero through per-entry valid flops; uses ffba_pkg
module ffba_marker_mem #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDX_W-1:0]     rd_addr,
    output ffba_pkg::mark_t      rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  ffba_pkg::mark_t      wr_data
);
    import ffba_pkg::*;

    mark_t            mem [DEPTH];
    mark_t            rd_data_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

[rtl/core/first_fit_block_allocator.sv]
// first_fit_block_allocator: first-fit allocator over NUM_BLOCKS fixed blocks
// depends on ffba_pkg and ffba_marker_mem
//
// Usage:
//   s_axis: one transaction per command; tuser is the command (0 allocate,
//   1 free), tdata carries request_bytes and address.
//   m_axis: one transaction per command with status, granted address,
//   blocks freed and free bytes after the command.
//   cfg_we / cfg_wdata write base_address; write only while the block is idle.
// Timing:
//   one command at a time; s_axis_tready is high only while idle.
//   allocate walks the marker memory one entry per cycle (pipelined reads),
//   then one write per claimed block.
//   free steps the offset down by BLOCK_BYTES once per cycle to find the
//   block, then walks the run, one per block.
//   a zero-size request or an address outside the heap goes straight to output.
// Reset: every block free, base_address 256, output empty.
// Stall: the result waits in the output register; the next command is
//   accepted meanwhile and its result waits until that register drains.
module first_fit_block_allocator #(
    parameter int NUM_BLOCKS  = 64,
    parameter int BLOCK_BYTES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // request_bytes [15:0], address [31:16]
    input  logic [ffba_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // cmd [0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status [1:0], granted_address [17:2], blocks_freed [24:18], free_bytes [35:25]
    output logic [ffba_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [ffba_pkg::ADDR_W-1:0]        cfg_wdata
);
    import ffba_pkg::*;

    localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int SPAN   = (NUM_BLOCKS - 1) * BLOCK_BYTES;
    localparam int RUN_W  = ADDR_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [CNT_W-1:0]  NUM_CNT  = CNT_W'(NUM_BLOCKS);
    localparam logic [ADDR_W-1:0] BB_ADDR  = ADDR_W'(BLOCK_BYTES);
    localparam logic [RUN_W-1:0]  BB_RUN   = RUN_W'(BLOCK_BYTES);
    localparam logic [RUN_W-1:0]  SPAN_RUN = RUN_W'(SPAN);

    logic [2:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     base_reg, base_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [ADDR_W-1:0]     off_reg, off_next;
    logic [CNT_W-1:0]      iss_reg, iss_next;
    logic [CNT_W-1:0]      chk_reg, chk_next;
    logic                  pend_reg, pend_next;
    logic [RUN_W-1:0]      run_bytes_reg, run_bytes_next;
    logic [CNT_W-1:0]      start_idx_reg, start_idx_next;
    logic [ADDR_W-1:0]     start_addr_reg, start_addr_next;
    logic [ADDR_W-1:0]     cur_addr_reg, cur_addr_next;
    logic [CNT_W-1:0]      free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0]      freed_reg, freed_next;
    status_t               res_status_reg, res_status_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic                  out_vld_reg, out_vld_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                  in_acc;
    logic                  in_cmd;
    logic [REQ_W-1:0]      in_req;
    logic [ADDR_W-1:0]     in_addr;
    logic [RUN_W-1:0]      last_addr;
    logic [RUN_W-1:0]      run_sum;
    logic [IDX_W-1:0]      rd_addr;
    mark_t                 rd_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    mark_t                 wr_data;
    mark_t                 chk_mark;
    logic [31:0]           fb_full;
    logic [31:0]           freed_full;

    ffba_marker_mem #(
        .DEPTH (NUM_BLOCKS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = s_axis_tuser;
    assign in_req        = s_axis_tdata[REQ_W-1:0];
    assign in_addr       = s_axis_tdata[IN_DATA_W-1:REQ_W];
    assign last_addr     = {1'b0, base_reg} + SPAN_RUN;
    assign run_sum       = run_bytes_reg + BB_RUN;
    assign rd_addr       = iss_reg[IDX_W-1:0];
    assign chk_mark      = MARK_W'(start_idx_reg) + MARK_W'(1);
    assign fb_full       = 32'(free_cnt_reg) * 32'(BLOCK_BYTES);
    assign freed_full    = 32'(freed_reg);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        base_next       = cfg_we ? cfg_wdata : base_reg;
        req_next        = req_reg;
        off_next        = off_reg;
        iss_next        = iss_reg;
        chk_next        = chk_reg;
        pend_next       = 1'b0;
        run_bytes_next  = run_bytes_reg;
        start_idx_next  = start_idx_reg;
        start_addr_next = start_addr_reg;
        cur_addr_next   = cur_addr_reg;
        free_cnt_next   = free_cnt_reg;
        freed_next      = freed_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_vld_next    = out_vld_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_addr         = chk_reg[IDX_W-1:0];
        wr_data         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    freed_next      = '0;
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    iss_next        = '0;
                    chk_next        = '0;
                    if (in_cmd == CMD_ALLOC)
                    begin
                        if (in_req == '0)
                        begin
                            res_status_next = ST_ZERO_SIZE;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            req_next       = in_req;
                            run_bytes_next = '0;
                            cur_addr_next  = base_reg;
                            state_next     = S_SCAN;
                        end
                    end
                    else
                    begin
                        if ((in_addr < base_reg) || ({1'b0, in_addr} > last_addr))
                        begin
                            res_status_next = ST_BAD_ADDR;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            off_next   = in_addr - base_reg;
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (iss_reg < NUM_CNT)
                begin
                    iss_next  = iss_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    chk_next      = chk_reg + CNT_W'(1);
                    cur_addr_next = cur_addr_reg + BB_ADDR;
                    if (rd_data == '0)
                    begin
                        if (run_bytes_reg == '0)
                        begin
                            start_idx_next  = chk_reg;
                            start_addr_next = cur_addr_reg;
                        end
                        run_bytes_next = run_sum;
                        if (run_sum >= {1'b0, req_reg})
                        begin
                            chk_next   = (run_bytes_reg == '0) ? chk_reg : start_idx_reg;
                            iss_next   = chk_reg;
                            pend_next  = 1'b0;
                            state_next = S_FILL;
                        end
                    end
                    else
                    begin
                        run_bytes_next = '0;
                    end
                end
                else if (iss_reg == NUM_CNT)
                begin
                    res_status_next = ST_NO_MEM;
                    state_next      = S_OUT;
                end
            end
            S_FILL:
            begin
                wr_en         = 1'b1;
                wr_data       = MARK_W'(start_idx_reg) + MARK_W'(1);
                free_cnt_next = free_cnt_reg - CNT_W'(1);
                chk_next      = chk_reg + CNT_W'(1);
                if (chk_reg == iss_reg)
                begin
                    res_status_next = ST_OK;
                    res_addr_next   = start_addr_reg;
                    state_next      = S_OUT;
                end
            end
            S_DIV:
            begin
                if (off_reg >= BB_ADDR)
                begin
                    off_next = off_reg - BB_ADDR;
                    chk_next = chk_reg + CNT_W'(1);
                end
                else
                begin
                    iss_next       = chk_reg;
                    start_idx_next = chk_reg;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                if (iss_reg < NUM_CNT)
                begin
                    iss_next  = iss_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if (rd_data == chk_mark)
                    begin
                        wr_en         = 1'b1;
                        wr_data       = '0;
                        free_cnt_next = free_cnt_reg + CNT_W'(1);
                        freed_next    = freed_reg + CNT_W'(1);
                        chk_next      = chk_reg + CNT_W'(1);
                    end
                    else
                    begin
                        pend_next  = 1'b0;
                        state_next = S_OUT;
                    end
                end
                else if (iss_reg == NUM_CNT)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = {OUT_PAD_W'(0), fb_full[FBYTES_W-1:0],
                                     freed_full[FREED_W-1:0], res_addr_reg,
                                     res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            base_reg     <= ADDR_W'(256);
            iss_reg      <= '0;
            chk_reg      <= '0;
            pend_reg     <= 1'b0;
            free_cnt_reg <= NUM_CNT;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            iss_reg      <= iss_next;
            chk_reg      <= chk_next;
            pend_reg     <= pend_next;
            free_cnt_reg <= free_cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        off_reg        <= off_next;
        run_bytes_reg  <= run_bytes_next;
        start_idx_reg  <= start_idx_next;
        start_addr_reg <= start_addr_next;
        cur_addr_reg   <= cur_addr_next;
        freed_reg      <= freed_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_data_reg   <= out_data_next;
    end

endmodule
